### rtl/cxpc_pkg.sv
`default_nettype none

package cxpc_pkg;

    localparam int LENGTH_BITS   = 16;
    localparam int COUNT_W       = LENGTH_BITS + 1;
    localparam int PAYLOAD_LEN_W = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_FIXED_KEY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEND_KEY  = 2'd1;

    localparam logic [7:0] FIXED_KEY_RESET = 8'hA9;
    localparam logic [7:0] SEND_KEY_RESET  = 8'h31;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic [7:0] packet_key;
        logic [7:0] expected_checksum;
    } cxpc_in_t;

    typedef struct packed {
        logic [7:0]               out_byte;
        logic                     end_of_packet;
        logic [7:0]               checksum;
        logic [PAYLOAD_LEN_W-1:0] payload_length;
        logic                     checksum_ok;
        logic                     too_long;
    } cxpc_out_t;

    // keystream byte for one stage: previous stage output + key + index + 1
    function automatic logic [7:0] stage_pad(input logic [7:0] chain,
                                             input logic [7:0] key,
                                             input logic [7:0] pos);
        stage_pad = chain + key + pos + 8'd1;
    endfunction

endpackage

`default_nettype wire

### rtl/chained_xor_packet_codec.sv
// The result of an accepted input transaction appears on m_data in the next cycle.
// Throughput: one byte per cycle while m_ready is high; the chain, index, sum and count registers
// update in the same cycle the byte is accepted, and one output register holds the result.
// Reset (aresetn low, synchronous): keys return to 0xA9 (fixed) and 0x31 (send),
// chains, index, sum, count and held header values clear, output goes invalid.
`default_nettype none

module chained_xor_packet_codec
    import cxpc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cxpc_in_t               s_data,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output cxpc_out_t                   m_data
);

    logic [7:0]         fixed_key_reg;
    logic [7:0]         send_key_reg;
    logic [7:0]         key_chain_reg,  key_chain_next;
    logic [7:0]         fixed_chain_reg, fixed_chain_next;
    logic [7:0]         pos_reg,        pos_next;
    logic [7:0]         sum_reg,        sum_next;
    logic [COUNT_W-1:0] count_reg,      count_next;
    logic [7:0]         pkey_reg,       pkey_next;
    logic [7:0]         exp_sum_reg,    exp_sum_next;
    logic               m_valid_reg;
    cxpc_out_t          m_data_reg,     m_data_next;

    logic                   accept;
    logic [7:0]             key_chain_cur;
    logic [7:0]             fixed_chain_cur;
    logic [7:0]             pos_cur;
    logic [7:0]             sum_cur;
    logic [COUNT_W-1:0]     count_cur;
    logic [7:0]             mid;
    logic [7:0]             plain;
    logic [7:0]             result;
    logic [LENGTH_BITS-1:0] shown;

    // output register frees up when it is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        // first byte restarts the packet state
        key_chain_cur   = s_data.first ? 8'd0 : key_chain_reg;
        fixed_chain_cur = s_data.first ? 8'd0 : fixed_chain_reg;
        pos_cur         = s_data.first ? 8'd0 : pos_reg;
        sum_cur         = s_data.first ? 8'd0 : sum_reg;
        count_cur       = s_data.first ? '0   : count_reg;
        pkey_next       = s_data.first ? s_data.packet_key        : pkey_reg;
        exp_sum_next    = s_data.first ? s_data.expected_checksum : exp_sum_reg;

        if (s_data.mode == MODE_ENCODE) begin
            plain            = s_data.data_byte;
            mid              = plain ^ stage_pad(key_chain_cur, send_key_reg, pos_cur);
            result           = mid ^ stage_pad(fixed_chain_cur, fixed_key_reg, pos_cur);
            key_chain_next   = mid;
            fixed_chain_next = result;
        end else begin
            mid              = s_data.data_byte
                               ^ stage_pad(fixed_chain_cur, fixed_key_reg, pos_cur);
            plain            = mid ^ stage_pad(key_chain_cur, pkey_next, pos_cur);
            result           = plain;
            key_chain_next   = mid;
            fixed_chain_next = s_data.data_byte;
        end

        sum_next = sum_cur + plain;
        pos_next = pos_cur + 8'd1;
        // top bit set means the packet overran; hold there
        count_next = count_cur[LENGTH_BITS] ? count_cur : count_cur + COUNT_W'(1);
        shown      = count_next[LENGTH_BITS] ? {LENGTH_BITS{1'b1}}
                                             : count_next[LENGTH_BITS-1:0];

        m_data_next.out_byte       = result;
        m_data_next.end_of_packet  = s_data.last;
        m_data_next.checksum       = sum_next;
        m_data_next.payload_length = PAYLOAD_LEN_W'(shown);
        m_data_next.checksum_ok    = (s_data.mode == MODE_ENCODE)
                                     || (s_data.last && (sum_next == exp_sum_next));
        m_data_next.too_long       = count_next[LENGTH_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_key_reg   <= FIXED_KEY_RESET;
            send_key_reg    <= SEND_KEY_RESET;
            key_chain_reg   <= '0;
            fixed_chain_reg <= '0;
            pos_reg         <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            pkey_reg        <= '0;
            exp_sum_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FIXED_KEY: fixed_key_reg <= cfg_wdata;
                    REG_SEND_KEY:  send_key_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                key_chain_reg   <= key_chain_next;
                fixed_chain_reg <= fixed_chain_next;
                pos_reg         <= pos_next;
                sum_reg         <= sum_next;
                count_reg       <= count_next;
                pkey_reg        <= pkey_next;
                exp_sum_reg     <= exp_sum_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted transaction produced no result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    a_first_length_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.first) |=> (m_data.payload_length == PAYLOAD_LEN_W'(1)
                                      && !m_data.too_long))
        else $error("first byte did not restart the length count");

    a_encode_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode == MODE_ENCODE) |=> m_data.checksum_ok)
        else $error("encode result without checksum_ok");

endmodule

`default_nettype wire

### dv/tb_chained_xor_packet_codec.sv
`timescale 1ns / 1ps

module tb_chained_xor_packet_codec
    import cxpc_pkg::*;
();

    localparam logic [COUNT_W-1:0]     LENGTH_MAX        = COUNT_W'((1 << LENGTH_BITS) - 1);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH    = 2'd3;
    localparam int                     PHASES            = 6;
    localparam int                     PHASE_BYTES       = 260;
    localparam int                     QUIET_LIMIT       = 2000;
    localparam int                     REPORT_LIMIT      = 100;

    typedef logic [7:0] byte_q_t[$];

    class xor_codec_scoreboard;
        logic [7:0]         fixed_key;
        logic [7:0]         send_key;
        logic [7:0]         key_chain;
        logic [7:0]         fixed_chain;
        logic [7:0]         position;
        logic [7:0]         plain_total;
        logic [7:0]         header_key;
        logic [7:0]         header_sum;
        logic [COUNT_W-1:0] byte_total;
        cxpc_out_t          awaited[$];
        int                 errors;

        function new();
            fixed_key   = FIXED_KEY_RESET;
            send_key    = SEND_KEY_RESET;
            key_chain   = '0;
            fixed_chain = '0;
            position    = '0;
            plain_total = '0;
            header_key  = '0;
            header_sum  = '0;
            byte_total  = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [7:0] value);
            if (index == REG_FIXED_KEY) begin
                fixed_key = value;
            end else if (index == REG_SEND_KEY) begin
                send_key = value;
            end
        endfunction

        // run one byte through both XOR stages and queue the result it must produce
        function void accept_byte(cxpc_in_t t);
            cxpc_out_t          r;
            logic [7:0]         plain;
            logic [7:0]         mid;
            logic [7:0]         key_pad;
            logic [7:0]         fixed_pad;
            logic [COUNT_W-1:0] shown;
            if (t.first) begin
                key_chain   = '0;
                fixed_chain = '0;
                position    = '0;
                plain_total = '0;
                byte_total  = '0;
                header_key  = t.packet_key;
                header_sum  = t.expected_checksum;
            end
            fixed_pad = fixed_chain + fixed_key + position + 8'd1;
            if (t.mode == MODE_ENCODE) begin
                key_pad     = key_chain + send_key + position + 8'd1;
                plain       = t.data_byte;
                mid         = plain ^ key_pad;
                key_chain   = mid;
                r.out_byte  = mid ^ fixed_pad;
                fixed_chain = r.out_byte;
            end else begin
                key_pad     = key_chain + header_key + position + 8'd1;
                mid         = t.data_byte ^ fixed_pad;
                fixed_chain = t.data_byte;
                plain       = mid ^ key_pad;
                key_chain   = mid;
                r.out_byte  = plain;
            end
            plain_total = plain_total + plain;
            position    = position + 8'd1;
            if (byte_total <= LENGTH_MAX) begin
                byte_total = byte_total + COUNT_W'(1);
            end
            shown             = (byte_total > LENGTH_MAX) ? LENGTH_MAX : byte_total;
            r.end_of_packet   = t.last;
            r.checksum        = plain_total;
            r.payload_length  = shown[PAYLOAD_LEN_W-1:0];
            r.checksum_ok     = (t.mode == MODE_ENCODE) || (t.last && plain_total == header_sum);
            r.too_long        = byte_total > LENGTH_MAX;
            awaited.push_back(r);
        endfunction

        function void compare(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                // keep the log readable once a real bug floods it
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                end
            end
        endfunction

        function void check_output(cxpc_out_t got);
            cxpc_out_t want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: result with nothing awaited, actual %p", $time, got);
                end
                return;
            end
            want = awaited.pop_front();
            compare("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare("end_of_packet", 16'(want.end_of_packet), 16'(got.end_of_packet));
            compare("checksum", 16'(want.checksum), 16'(got.checksum));
            compare("payload_length", want.payload_length, got.payload_length);
            compare("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
            compare("too_long", 16'(want.too_long), 16'(got.too_long));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    cxpc_in_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    cxpc_out_t              m_data;

    xor_codec_scoreboard board;
    xor_codec_scoreboard cipher;
    bit                  fast_source;
    bit                  fast_sink;
    int                  sent_count;
    int                  quiet_cycles;
    logic [7:0]          fixed_plan[PHASES] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h5C, 8'hA3};
    logic [7:0]          send_plan[PHASES]  = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h3A, 8'hC5};

    chained_xor_packet_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_item(input cxpc_in_t item);
        int gap;
        gap = fast_source ? 0 : $urandom_range(0, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = item;
        do @(posedge aclk); while (!s_ready);
        board.accept_byte(item);
        sent_count++;
    endtask

    // decode packets carry bytes that the cipher copy sealed with the given key
    task automatic send_packet(input logic mode, input byte_q_t plain, input logic [7:0] key,
                               input logic [7:0] sum_skew, input bit closed);
        cxpc_in_t   item;
        cxpc_out_t  sealed;
        logic [7:0] total;
        total = 8'd0;
        foreach (plain[i]) total += plain[i];
        cipher.write_reg(REG_FIXED_KEY, board.fixed_key);
        cipher.write_reg(REG_SEND_KEY, key);
        foreach (plain[i]) begin
            item.mode              = MODE_ENCODE;
            item.data_byte         = plain[i];
            item.first             = (i == 0);
            item.last              = closed && (i == plain.size() - 1);
            item.packet_key        = (i == 0) ? key : 8'($urandom);
            item.expected_checksum = (i == 0) ? total + sum_skew : 8'($urandom);
            if (mode == MODE_DECODE) begin
                cipher.accept_byte(item);
                sealed         = cipher.awaited.pop_back();
                item.data_byte = sealed.out_byte;
                item.mode      = MODE_DECODE;
            end
            send_item(item);
        end
    endtask

    // bytes with no first mark continue whatever packet is open, in either mode
    task automatic send_loose(input int count);
        cxpc_in_t loose;
        repeat (count) begin
            loose.mode              = ($urandom_range(0, 1) == 0) ? MODE_ENCODE : MODE_DECODE;
            loose.data_byte         = 8'($urandom);
            loose.first             = 1'b0;
            loose.last              = ($urandom_range(0, 7) == 0);
            loose.packet_key        = 8'($urandom);
            loose.expected_checksum = 8'($urandom);
            send_item(loose);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.awaited.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic program_key(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        board.write_reg(index, value);
    endtask

    // result side: random stall, then take one transaction
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = fast_sink ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_output(m_data);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_chained_xor_packet_codec: FAIL");
                $finish;
            end
        end
    end

    initial begin
        byte_q_t    plain;
        int         phase_end;
        int         roll;
        int         length;
        board        = new();
        cipher       = new();
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        fast_source  = 1'b0;
        fast_sink    = 1'b0;
        sent_count   = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // bytes straight out of reset run on zero chains and zero header values
        send_loose(6);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            program_key(REG_FIXED_KEY, fixed_plan[p]);
            program_key(REG_SEND_KEY, send_plan[p]);
            // writes to spare indexes must be dropped
            program_key(REG_SPARE_LOW, 8'($urandom));
            program_key(REG_SPARE_HIGH, 8'($urandom));
            fast_source = (p == 2) || (p == 3);
            fast_sink   = (p == 2) || (p == 5);
            phase_end   = sent_count + PHASE_BYTES;
            if (p == 1 || p == 4) begin
                // long enough for the byte index to wrap
                plain.delete();
                repeat (258) plain.push_back(8'($urandom));
                send_packet((p == 1) ? MODE_ENCODE : MODE_DECODE, plain, 8'($urandom),
                            8'd0, 1'b1);
            end
            while (sent_count < phase_end) begin
                roll   = $urandom_range(0, 9);
                length = $urandom_range(1, 24);
                if (length > phase_end - sent_count) begin
                    length = phase_end - sent_count;
                end
                plain.delete();
                repeat (length) plain.push_back(8'($urandom));
                if (roll < 4) begin
                    send_packet(MODE_ENCODE, plain, 8'($urandom), 8'd0, roll != 3);
                end else if (roll < 8) begin
                    send_packet(MODE_DECODE, plain, 8'($urandom),
                                (roll == 7) ? 8'($urandom_range(1, 255)) : 8'd0, roll != 6);
                end else begin
                    send_loose(length);
                end
            end
        end

        drain();
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("tb_chained_xor_packet_codec: PASS");
        end else begin
            $display("tb_chained_xor_packet_codec: FAIL");
        end
        $finish;
    end

endmodule
